[rtl/core/dcb_pkg.sv]
// ----------------------------------------------------------------------------
// dcb_pkg: shared types and constants of the Crystal Ball evaluator
// Region and register codes, the shift-add log table, the words handed along
// the cell chains.
// ----------------------------------------------------------------------------
package dcb_pkg;

  localparam int MAX_STAGES        = 40;
  localparam int CORDIC_STAGES_DEF = 24;

  // result region, carried as tuser
  typedef enum logic [1:0] {
    REGION_LEFT  = 2'd0,
    REGION_CORE  = 2'd1,
    REGION_RIGHT = 2'd2
  } region_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MEAN        = 3'd0,
    CFG_WIDTH       = 3'd1,
    CFG_LEFT_CUT    = 3'd2,
    CFG_LEFT_POWER  = 3'd3,
    CFG_RIGHT_CUT   = 3'd4,
    CFG_RIGHT_POWER = 3'd5
  } cfg_index_t;

  typedef logic [39:0] ln_tab_t [0:MAX_STAGES];

  // ln(1 + 2^-i) in Q.40 for i >= 1, ln 2 at entry zero; series in Q.62
  function automatic ln_tab_t build_ln_tab();
    ln_tab_t            t;
    logic [63:0]        s;
    logic signed [63:0] acc;
    logic [63:0]        term;
    s = '0;
    for (int k = 1; k <= 62; k++) begin
      s = s + ((64'd1 << (62 - k)) / 64'(k));
    end
    t[0] = 40'((s + (64'd1 << 21)) >> 22);
    for (int i = 1; i <= MAX_STAGES; i++) begin
      acc = '0;
      for (int k = 1; i * k <= 62; k++) begin
        term = (64'd1 << (62 - i * k)) / 64'(k);
        if (k % 2 == 1) begin
          acc = acc + $signed(term);
        end else begin
          acc = acc - $signed(term);
        end
      end
      t[i] = 40'(($unsigned(acc) + (64'd1 << 21)) >> 22);
    end
    return t;
  endfunction

  localparam ln_tab_t     LN_TAB = build_ln_tab();
  localparam logic [39:0] LN2    = LN_TAB[0];

  // divider word: dividend bits shift out at the top, quotient bits in below
  typedef struct packed {
    logic        neg;
    logic [47:0] bits;
    logic [30:0] rem;
  } div_word_t;

  typedef struct packed {
    logic [22:0] n;
    logic [40:0] base;
    region_t     region;
  } tail_side_t;

  typedef struct packed {
    logic [63:0] vn;
    logic [63:0] vd;
    logic [5:0]  lzn;
    logic [5:0]  lzd;
    tail_side_t  side;
  } norm_word_t;

  typedef struct packed {
    logic [40:0] m;
    logic [41:0] p;
    logic [40:0] acc;
    logic [5:0]  k;
  } log_lane_t;

  typedef struct packed {
    log_lane_t  ln_num;
    log_lane_t  ln_den;
    tail_side_t side;
  } log_word_t;

  typedef struct packed {
    logic [44:0] rem;
    logic [5:0]  k;
    logic        zero;
    logic        big;
    region_t     region;
  } qd_word_t;

  typedef struct packed {
    logic [39:0] r;
    logic [41:0] y;
    logic [5:0]  k;
    logic        zero;
    logic        big;
    region_t     region;
  } exp_word_t;

endpackage

[rtl/core/dcb_div_cell.sv]
// ----------------------------------------------------------------------------
// dcb_div_cell: one quotient bit of the (x - mu) / sigma divider
// Restoring step: shift in one dividend bit, subtract sigma if it fits.
// ----------------------------------------------------------------------------
module dcb_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [30:0]         sg,
  input  logic                in_valid,
  input  dcb_pkg::div_word_t  in_word,
  output logic                out_valid,
  output dcb_pkg::div_word_t  out_word
);
  import dcb_pkg::*;

  logic [31:0] trial;
  logic        fits;
  div_word_t   step;

  // try the subtract on the widened remainder
  always_comb begin
    trial         = {in_word.rem, in_word.bits[47]};
    fits          = (trial >= {1'b0, sg});
    step.neg      = in_word.neg;
    step.bits     = {in_word.bits[46:0], fits};
    step.rem      = fits ? 31'(trial - {1'b0, sg}) : trial[30:0];
  end

  // advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= step;
    end
  end

endmodule

[rtl/core/dcb_norm_cell.sv]
// ----------------------------------------------------------------------------
// dcb_norm_cell: one level of the leading-one normalizer
// Shifts both log arguments left by a fixed power of two where the top bits
// are clear and records that bit of the leading-zero count.
// ----------------------------------------------------------------------------
module dcb_norm_cell #(
  parameter int LEVEL = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  dcb_pkg::norm_word_t in_word,
  output logic                out_valid,
  output dcb_pkg::norm_word_t out_word
);
  import dcb_pkg::*;

  localparam int SH  = 32 >> LEVEL;
  localparam int BIT = 5 - LEVEL;

  norm_word_t step;

  // shift each lane where its top SH bits are zero
  always_comb begin
    step = in_word;
    if (in_word.vn[63 -: SH] == '0) begin
      step.vn       = in_word.vn << SH;
      step.lzn[BIT] = 1'b1;
    end
    if (in_word.vd[63 -: SH] == '0) begin
      step.vd       = in_word.vd << SH;
      step.lzd[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= step;
    end
  end

endmodule

[rtl/core/dcb_log_cell.sv]
// ----------------------------------------------------------------------------
// dcb_log_cell: one shift-add step of the logarithm, both lanes
// Multiplies p by (1 + 2^-STAGE) where it stays at or below the mantissa and
// adds ln(1 + 2^-STAGE) to the sum.
// ----------------------------------------------------------------------------
module dcb_log_cell #(
  parameter int STAGE = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  dcb_pkg::log_word_t in_word,
  output logic               out_valid,
  output dcb_pkg::log_word_t out_word
);
  import dcb_pkg::*;

  function automatic log_lane_t lane_step(log_lane_t l);
    logic [41:0] q;
    log_lane_t   o;
    o = l;
    q = l.p + (l.p >> STAGE);
    if (q <= {1'b0, l.m}) begin
      o.p   = q;
      o.acc = l.acc + 41'(LN_TAB[STAGE]);
    end
    return o;
  endfunction

  log_word_t step;

  always_comb begin
    step        = in_word;
    step.ln_num = lane_step(in_word.ln_num);
    step.ln_den = lane_step(in_word.ln_den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= step;
    end
  end

endmodule

[rtl/core/dcb_exp_cell.sv]
// ----------------------------------------------------------------------------
// dcb_exp_cell: one shift-add step of the exponential
// Takes ln(1 + 2^-STAGE) off the residue where it fits and grows y to match.
// ----------------------------------------------------------------------------
module dcb_exp_cell #(
  parameter int STAGE = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  dcb_pkg::exp_word_t in_word,
  output logic               out_valid,
  output dcb_pkg::exp_word_t out_word
);
  import dcb_pkg::*;

  exp_word_t step;

  always_comb begin
    step = in_word;
    if (in_word.r >= LN_TAB[STAGE]) begin
      step.r = in_word.r - LN_TAB[STAGE];
      step.y = in_word.y + (in_word.y >> STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= step;
    end
  end

endmodule

[rtl/core/double_crystal_ball_eval.sv]
// ----------------------------------------------------------------------------
// double_crystal_ball_eval: pipelined double-sided Crystal Ball shape
// Forms u = (x - mu) / sigma, picks left tail, Gaussian core or right tail,
// and returns exp(-E) as unsigned Q1.31 with the region code.
//
//   channel  direction  word
//   s_*      in         tdata: sample (31:0)
//   m_*      out        tdata: density (31:0); tuser: region (1:0)
//   cfg_*    in         cfg_index (2:0), cfg_data (31:0)
//
// One sample per cycle while the skid register is empty; the latency is set by the
// 48-cell divider chain and the log and exp shift-add chains.
// Reset clears the valid bits and loads the register defaults; no sweep.
// A stalled result moves to a skid register; the pipeline freezes only
// while the skid register is full.
// ----------------------------------------------------------------------------
module double_crystal_ball_eval #(
  parameter int CORDIC_STAGES = dcb_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // density
  output logic [1:0]  m_tuser,   // region
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dcb_pkg::*;

  // configuration registers
  logic [31:0] mean;
  logic [30:0] width;
  logic [20:0] left_cut;
  logic [22:0] left_power;
  logic [20:0] right_cut;
  logic [22:0] right_power;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean        <= 32'd0;
      width       <= 31'd65536;
      left_cut    <= 21'd131072;
      left_power  <= 23'd327680;
      right_cut   <= 21'd131072;
      right_power <= 23'd327680;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MEAN:        mean        <= cfg_data;
        CFG_WIDTH:       width       <= cfg_data[30:0];
        CFG_LEFT_CUT:    left_cut    <= cfg_data[20:0];
        CFG_LEFT_POWER:  left_power  <= cfg_data[22:0];
        CFG_RIGHT_CUT:   right_cut   <= cfg_data[20:0];
        CFG_RIGHT_POWER: right_power <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // zero settings count as one LSB
  logic [30:0] sg;
  logic [20:0] a1e, a2e;
  logic [22:0] n1e, n2e;
  assign sg  = (width == '0)       ? 31'd1 : width;
  assign a1e = (left_cut == '0)    ? 21'd1 : left_cut;
  assign a2e = (right_cut == '0)   ? 21'd1 : right_cut;
  assign n1e = (left_power == '0)  ? 23'd1 : left_power;
  assign n2e = (right_power == '0) ? 23'd1 : right_power;

  // pipeline advance and output skid
  logic        en;
  logic        skid_v;
  logic [31:0] skid_dens;
  logic [1:0]  skid_region;
  assign en       = ~skid_v;
  assign s_tready = en;

  // ---- stage 0: difference magnitude and sign ----
  logic [32:0] diff;
  logic [32:0] mag;
  logic        div0_v;
  div_word_t   div0_w;
  assign diff = {s_tdata[31], s_tdata} - {mean[31], mean};
  assign mag  = diff[32] ? (33'd0 - diff) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      div0_v <= 1'b0;
    end else if (en) begin
      div0_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div0_w.neg  <= diff[32];
      div0_w.bits <= {mag[31:0], 16'd0};
      div0_w.rem  <= '0;
    end
  end

  // ---- divider chain ----
  logic      div_v [1:48];
  div_word_t div_w [1:48];

  for (genvar i = 1; i <= 48; i++) begin : g_div
    if (i == 1) begin : g_first
      dcb_div_cell u_cell (
        .clk(clk), .rst(rst), .en(en), .sg(sg),
        .in_valid(div0_v), .in_word(div0_w),
        .out_valid(div_v[i]), .out_word(div_w[i])
      );
    end else begin : g_next
      dcb_div_cell u_cell (
        .clk(clk), .rst(rst), .en(en), .sg(sg),
        .in_valid(div_v[i-1]), .in_word(div_w[i-1]),
        .out_valid(div_v[i]), .out_word(div_w[i])
      );
    end
  end

  // ---- region select and tail distance ----
  logic [47:0] q;
  logic        is_left, is_right;
  logic [20:0] a_sel;
  logic [22:0] n_sel;
  logic [47:0] gap;
  region_t     region_c;

  always_comb begin
    q        = div_w[48].bits;
    is_left  = div_w[48].neg && (q > 48'(a1e));
    is_right = !div_w[48].neg && (q >= 48'(a2e));
    a_sel    = is_left ? a1e : a2e;
    n_sel    = is_left ? n1e : n2e;
    gap      = q - 48'(a_sel);
    if (is_left) begin
      region_c = REGION_LEFT;
    end else if (is_right) begin
      region_c = REGION_RIGHT;
    end else begin
      region_c = REGION_CORE;
    end
  end

  logic        rg_v;
  region_t     rg_region;
  logic [20:0] rg_sel, rg_a;
  logic [41:0] rg_d;
  logic [22:0] rg_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      rg_v <= 1'b0;
    end else if (en) begin
      rg_v <= div_v[48];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rg_region <= region_c;
      rg_a      <= a_sel;
      rg_n      <= n_sel;
      if (region_c == REGION_CORE) begin
        rg_sel <= q[20:0];
        rg_d   <= '0;
      end else begin
        rg_sel <= a_sel;
        rg_d   <= (gap > 48'h3FF_FFFF_FFFF) ? 42'h3FF_FFFF_FFFF : gap[41:0];
      end
    end
  end

  // ---- square and tail product ----
  logic        m1_v;
  logic [41:0] m1_sq;
  logic [62:0] m1_da;
  logic [22:0] m1_n;
  region_t     m1_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= rg_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sq     <= rg_sel * rg_sel;
      m1_da     <= rg_d * rg_a;
      m1_n      <= rg_n;
      m1_region <= rg_region;
    end
  end

  // ---- log arguments: N = n*2^16 + d*a, D = n*2^16 ----
  logic       nrm0_v;
  norm_word_t nrm0_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm0_v <= 1'b0;
    end else if (en) begin
      nrm0_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm0_w.vn          <= 64'({m1_n, 16'd0}) + 64'(m1_da);
      nrm0_w.vd          <= 64'({m1_n, 16'd0});
      nrm0_w.lzn         <= '0;
      nrm0_w.lzd         <= '0;
      nrm0_w.side.n      <= m1_n;
      nrm0_w.side.base   <= m1_sq[41:1];
      nrm0_w.side.region <= m1_region;
    end
  end

  // ---- normalizer chain ----
  logic       nrm_v [1:6];
  norm_word_t nrm_w [1:6];

  for (genvar j = 1; j <= 6; j++) begin : g_norm
    if (j == 1) begin : g_first
      dcb_norm_cell #(.LEVEL(j - 1)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(nrm0_v), .in_word(nrm0_w),
        .out_valid(nrm_v[j]), .out_word(nrm_w[j])
      );
    end else begin : g_next
      dcb_norm_cell #(.LEVEL(j - 1)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(nrm_v[j-1]), .in_word(nrm_w[j-1]),
        .out_valid(nrm_v[j]), .out_word(nrm_w[j])
      );
    end
  end

  // ---- log chain: mantissa in Q.40, exponent k = 63 - leading zeros ----
  log_word_t log_init;

  always_comb begin
    log_init.ln_num.m   = nrm_w[6].vn[63:23];
    log_init.ln_num.p   = 42'd1 << 40;
    log_init.ln_num.acc = '0;
    log_init.ln_num.k   = ~nrm_w[6].lzn;
    log_init.ln_den.m   = nrm_w[6].vd[63:23];
    log_init.ln_den.p   = 42'd1 << 40;
    log_init.ln_den.acc = '0;
    log_init.ln_den.k   = ~nrm_w[6].lzd;
    log_init.side       = nrm_w[6].side;
  end

  logic      log_v [1:CORDIC_STAGES];
  log_word_t log_w [1:CORDIC_STAGES];

  for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_log
    if (i == 1) begin : g_first
      dcb_log_cell #(.STAGE(i)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(nrm_v[6]), .in_word(log_init),
        .out_valid(log_v[i]), .out_word(log_w[i])
      );
    end else begin : g_next
      dcb_log_cell #(.STAGE(i)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(log_v[i-1]), .in_word(log_w[i-1]),
        .out_valid(log_v[i]), .out_word(log_w[i])
      );
    end
  end

  // ---- ln values, difference, tail exponent ----
  logic        l1_v, l2_v, p1_v, p2_v;
  logic [45:0] l1_lnn, l1_lnd;
  tail_side_t  l1_side, l2_side;
  logic [37:0] l2_lgs;
  logic [60:0] p1_prod;
  logic [40:0] p1_base;
  region_t     p1_region, p2_region;
  logic [45:0] p2_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_v <= 1'b0;
      l2_v <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else if (en) begin
      l1_v <= log_v[CORDIC_STAGES];
      l2_v <= l1_v;
      p1_v <= l2_v;
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_lnn    <= 46'(log_w[CORDIC_STAGES].ln_num.k) * 46'(LN2)
                 + 46'(log_w[CORDIC_STAGES].ln_num.acc);
      l1_lnd    <= 46'(log_w[CORDIC_STAGES].ln_den.k) * 46'(LN2)
                 + 46'(log_w[CORDIC_STAGES].ln_den.acc);
      l1_side   <= log_w[CORDIC_STAGES].side;
      l2_lgs    <= (l1_lnn > l1_lnd) ? 38'((l1_lnn - l1_lnd) >> 8) : 38'd0;
      l2_side   <= l1_side;
      p1_prod   <= l2_side.n * l2_lgs;
      p1_base   <= l2_side.base;
      p1_region <= l2_side.region;
      p2_e      <= (p1_region == REGION_CORE) ? 46'(p1_base)
                 : 46'(p1_base) + 46'(p1_prod >> 16);
      p2_region <= p1_region;
    end
  end

  // ---- range reduction: k = floor(e / ln 2), one quotient bit a stage ----
  function automatic qd_word_t qd_step(qd_word_t w, int b);
    logic [44:0] lim;
    qd_word_t    o;
    o   = w;
    lim = 45'(LN2) << b;
    if (w.rem >= lim) begin
      o.rem = w.rem - lim;
      o.k   = w.k | (6'd1 << b);
    end
    return o;
  endfunction

  logic     qd_v [0:6];
  qd_word_t qd_w [0:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= 6; j++) begin
        qd_v[j] <= 1'b0;
      end
    end else if (en) begin
      qd_v[0] <= p2_v;
      for (int j = 0; j < 6; j++) begin
        qd_v[j+1] <= qd_v[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_w[0].rem    <= {p2_e[36:0], 8'd0};
      qd_w[0].k      <= '0;
      qd_w[0].zero   <= (p2_e == '0);
      qd_w[0].big    <= |p2_e[45:37];
      qd_w[0].region <= p2_region;
      for (int j = 0; j < 6; j++) begin
        qd_w[j+1] <= qd_step(qd_w[j], 5 - j);
      end
    end
  end

  // ---- exp chain ----
  exp_word_t exp_init;

  always_comb begin
    exp_init.r      = LN2 - qd_w[6].rem[39:0];
    exp_init.y      = 42'd1 << 40;
    exp_init.k      = qd_w[6].k;
    exp_init.zero   = qd_w[6].zero;
    exp_init.big    = qd_w[6].big;
    exp_init.region = qd_w[6].region;
  end

  logic      exp_v [1:CORDIC_STAGES];
  exp_word_t exp_w [1:CORDIC_STAGES];

  for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_exp
    if (i == 1) begin : g_first
      dcb_exp_cell #(.STAGE(i)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(qd_v[6]), .in_word(exp_init),
        .out_valid(exp_v[i]), .out_word(exp_w[i])
      );
    end else begin : g_next
      dcb_exp_cell #(.STAGE(i)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(exp_v[i-1]), .in_word(exp_w[i-1]),
        .out_valid(exp_v[i]), .out_word(exp_w[i])
      );
    end
  end

  // ---- final rounding shift by k + 10 and saturation ----
  exp_word_t   ew;
  logic [6:0]  sh_m1;
  logic [41:0] y_sh;
  logic [33:0] rnd;
  logic [31:0] dens_c;

  always_comb begin
    ew    = exp_w[CORDIC_STAGES];
    sh_m1 = 7'(ew.k) + 7'd9;
    y_sh  = ew.y >> sh_m1;
    rnd   = (34'(y_sh) + 34'd1) >> 1;
    if (ew.zero) begin
      dens_c = 32'h8000_0000;
    end else if (ew.big) begin
      dens_c = 32'd0;
    end else if (rnd > 34'h0_8000_0000) begin
      dens_c = 32'h8000_0000;
    end else begin
      dens_c = rnd[31:0];
    end
  end

  logic        f_v;
  logic [31:0] f_dens;
  logic [1:0]  f_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= exp_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_dens   <= dens_c;
      f_region <= ew.region;
    end
  end

  // ---- output register with skid: park a word while the sink stalls ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (en) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= f_v;
      end else if (f_v) begin
        skid_v <= 1'b1;
      end
    end else if (m_tready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= f_dens;
        m_tuser <= f_region;
      end else begin
        skid_dens   <= f_dens;
        skid_region <= f_region;
      end
    end else if (m_tready) begin
      m_tdata <= skid_dens;
      m_tuser <= skid_region;
    end
  end

endmodule

[verif/double_crystal_ball_eval_tb.sv]
// ----------------------------------------------------------------------------
// double_crystal_ball_eval_tb: self-checking bench for the Crystal Ball shape
// Drives samples over the stream port under several register settings,
// predicts density and region in place, and checks every result word in
// order. Both sides idle at random; one phase runs with no idling.
// ----------------------------------------------------------------------------
module double_crystal_ball_eval_tb;
  import dcb_pkg::*;

  localparam int STAGES   = 24;
  localparam int LATENCY  = 71 + 2 * STAGES;
  localparam int LIMIT    = 400000;
  localparam int DIRECTED = 14;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic [31:0] density;
    region_t     region;
  } shape_t;

  // directed row: sample, whether the result is typed in, and that result
  typedef struct packed {
    logic [31:0] sample;
    logic        known;
    shape_t      result;
  } row_t;

  shape_t      shape_q[$];
  logic [39:0] ln_t [0:MAX_STAGES];
  logic [31:0] r_mean;
  logic [30:0] r_width;
  logic [20:0] r_lcut, r_rcut;
  logic [22:0] r_lpow, r_rpow;
  int          idle_pct = 35;
  int          cycles = 0;
  int          errors = 0;
  row_t        rows [DIRECTED];

  double_crystal_ball_eval #(.CORDIC_STAGES(STAGES)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hold a run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("double_crystal_ball_eval regression: fail");
      $finish;
    end
  end

  // series for ln 2 and ln(1 + 2^-i) in Q.62, rounded to Q.40
  function automatic void fill_ln_table();
    logic [63:0] s, term;
    longint acc;
    s = '0;
    for (int k = 1; k <= 62; k++) s += (64'd1 << (62 - k)) / k;
    ln_t[0] = 40'((s + (64'd1 << 21)) >> 22);
    for (int i = 1; i <= MAX_STAGES; i++) begin
      acc = 0;
      for (int k = 1; i * k <= 62; k++) begin
        term = (64'd1 << (62 - i * k)) / k;
        acc = (k % 2) ? acc + longint'(term) : acc - longint'(term);
      end
      ln_t[i] = 40'((64'(acc) + (64'd1 << 21)) >> 22);
    end
  endfunction

  function automatic logic [63:0] ln_q40(logic [63:0] v);
    int          k;
    logic [63:0] m, p, q, acc;
    k = 0;
    p = 64'd1 << 40;
    acc = '0;
    if (v == 0) v = 1;
    while (k < 63 && (v >> (k + 1)) != 0) k++;
    m = (k >= 40) ? (v >> (k - 40)) : (v << (40 - k));
    for (int i = 1; i <= STAGES; i++) begin
      q = p + (p >> i);
      if (q <= m) begin
        p = q;
        acc += ln_t[i];
      end
    end
    return 64'(k) * ln_t[0] + acc;
  endfunction

  function automatic logic [31:0] exp_neg(logic [63:0] e32);
    logic [63:0] e, k, r, y, res;
    int          s;
    y = 64'd1 << 40;
    if (e32 == 0) return 32'h8000_0000;
    if (e32 >= (64'd32 << 32)) return '0;
    e = e32 << 8;
    k = e / ln_t[0];
    r = ln_t[0] - (e - k * ln_t[0]);
    for (int i = 1; i <= STAGES; i++) begin
      if (r >= ln_t[i]) begin
        r -= ln_t[i];
        y += y >> i;
      end
    end
    s = int'(k) + 10;
    res = (y + (64'd1 << (s - 1))) >> s;
    if (res > (64'd1 << 31)) res = 64'd1 << 31;
    return res[31:0];
  endfunction

  function automatic logic [31:0] tail_density(logic [63:0] d, logic [63:0] a,
                                               logic [63:0] n);
    logic [63:0] den, num, lnn, lnd, lg;
    if (d > (64'd1 << 42) - 1) d = (64'd1 << 42) - 1;
    den = n << 16;
    num = den + d * a;
    lnn = ln_q40(num);
    lnd = ln_q40(den);
    lg = (lnn > lnd) ? lnn - lnd : '0;
    return exp_neg(((a * a) >> 1) + ((n * (lg >> 8)) >> 16));
  endfunction

  function automatic shape_t crystal_ball(logic [31:0] x);
    shape_t      o;
    longint      diff, u;
    logic [63:0] mag, q, sg, a1, a2, n1, n2;
    sg = r_width ? 64'(r_width) : 1;
    a1 = r_lcut ? 64'(r_lcut) : 1;
    a2 = r_rcut ? 64'(r_rcut) : 1;
    n1 = r_lpow ? 64'(r_lpow) : 1;
    n2 = r_rpow ? 64'(r_rpow) : 1;
    diff = longint'($signed(x)) - longint'($signed(r_mean));
    mag = 64'(diff < 0 ? -diff : diff);
    q = (mag << 16) / sg;
    u = diff < 0 ? -longint'(q) : longint'(q);
    if (u < -longint'(a1)) begin
      o.region = REGION_LEFT;
      o.density = tail_density(64'(-u - longint'(a1)), a1, n1);
    end else if (u < longint'(a2)) begin
      o.region = REGION_CORE;
      mag = 64'(u < 0 ? -u : u);
      o.density = exp_neg((mag * mag) >> 1);
    end else begin
      o.region = REGION_RIGHT;
      o.density = tail_density(64'(u - longint'(a2)), a2, n2);
    end
    return o;
  endfunction

  function automatic bit roll_idle();
    return $urandom_range(99) < idle_pct;
  endfunction

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (shape_q.size() == 0) begin
        $error("result with no prediction: density %h region %0d", m_tdata, m_tuser);
        errors++;
      end else begin
        if (m_tdata !== shape_q[0].density) begin
          $error("density: expected %h actual %h", shape_q[0].density, m_tdata);
          errors++;
        end
        if (m_tuser !== shape_q[0].region) begin
          $error("region: expected %0d actual %0d", shape_q[0].region, m_tuser);
          errors++;
        end
        void'(shape_q.pop_front());
      end
    end
  end

  // stall the result side at random
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : !roll_idle();
  end

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MEAN:        r_mean  = val;
      CFG_WIDTH:       r_width = val[30:0];
      CFG_LEFT_CUT:    r_lcut  = val[20:0];
      CFG_LEFT_POWER:  r_lpow  = val[22:0];
      CFG_RIGHT_CUT:   r_rcut  = val[20:0];
      CFG_RIGHT_POWER: r_rpow  = val[22:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_shape(logic [31:0] mu, logic [31:0] sg, logic [31:0] a1,
                           logic [31:0] n1, logic [31:0] a2, logic [31:0] n2);
    write_reg(CFG_MEAN, mu);
    write_reg(CFG_WIDTH, sg);
    write_reg(CFG_LEFT_CUT, a1);
    write_reg(CFG_LEFT_POWER, n1);
    write_reg(CFG_RIGHT_CUT, a2);
    write_reg(CFG_RIGHT_POWER, n2);
  endtask

  // send one sample word, optionally with a typed-in result; valid stays up
  // so the next word can follow at once
  task automatic send_sample(logic [31:0] x, bit known = 0, shape_t res = '0);
    while (roll_idle()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    shape_q.push_back(known ? res : crystal_ball(x));
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (shape_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // draw a sample near the peak in units of the width, or anywhere
  function automatic logic [31:0] pick_sample();
    longint sgm, off;
    sgm = r_width ? longint'(r_width) : 1;
    if ($urandom_range(9) < 7) begin
      off = (longint'($urandom_range(1600)) - 800) * sgm / 100;
      return 32'(longint'($signed(r_mean)) + off);
    end
    return $urandom;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
  endtask

  initial begin
    fill_ln_table();
    r_mean = '0;
    r_width = 31'd65536;
    r_lcut = 21'd131072;
    r_lpow = 23'd327680;
    r_rcut = 21'd131072;
    r_rpow = 23'd327680;
    rows = '{
      '{32'h0000_0000, 1'b1, '{32'h8000_0000, REGION_CORE}},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, '0},
      '{32'h0000_0001, 1'b0, '0},
      '{32'h0002_0000, 1'b0, '0},
      '{32'h0001_FFFF, 1'b0, '0},
      '{32'hFFFE_0000, 1'b0, '0},
      '{32'hFFFD_FFFF, 1'b0, '0},
      '{32'h0010_0000, 1'b0, '0},
      '{32'hFFF0_0000, 1'b0, '0},
      '{32'h0001_0000, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows under the reset settings
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);
    random_phase(300);
    drain();

    // unknown index is ignored; zero width, cuts and powers act as one LSB
    write_reg(cfg_index_t'(3'd7), 32'hDEAD_BEEF);
    write_reg(cfg_index_t'(3'd6), 32'h1234_5678);
    set_shape(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    random_phase(100);
    drain();

    // maximum registers, no idling on either side
    idle_pct = 0;
    set_shape(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1F_FFFF, 32'h7F_FFFF,
              32'h1F_FFFF, 32'h7F_FFFF);
    random_phase(300);
    drain();
    idle_pct = 35;

    // in-range extremes and mixed settings
    set_shape(32'hFFFF_0000, 32'h0000_8000, 32'h10_0000, 32'h40_0000, 32'h1, 32'h1);
    random_phase(300);
    drain();
    set_shape(32'h0003_0000, 32'h0000_0100, 32'h0000_4000, 32'h0001_0000,
              32'h0001_8000, 32'h0020_0000);
    random_phase(300);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_shape($urandom, $urandom_range(32'h7FFF_FFFF), $urandom_range(32'h1F_FFFF),
                $urandom_range(32'h7F_FFFF), $urandom_range(32'h1F_FFFF),
                $urandom_range(32'h7F_FFFF));
      random_phase(100);
      drain();
    end

    if (errors == 0) begin
      $display("double_crystal_ball_eval regression: pass");
    end else begin
      $display("double_crystal_ball_eval regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dcb_pkg.sv
rtl/core/dcb_div_cell.sv
rtl/core/dcb_norm_cell.sv
rtl/core/dcb_log_cell.sv
rtl/core/dcb_exp_cell.sv
rtl/core/double_crystal_ball_eval.sv
verif/double_crystal_ball_eval_tb.sv
